// ===== src/screen_delta_opcode_decoder_macros.svh =====
// ----------------------------------------------------------------------------
// screen_delta_opcode_decoder_macros: assertion macros
// Shared concurrent assertion forms. Each expects clk and rst_n in scope.
// ----------------------------------------------------------------------------
`ifndef SCREEN_DELTA_OPCODE_DECODER_MACROS_SVH
`define SCREEN_DELTA_OPCODE_DECODER_MACROS_SVH

// Same-cycle implication
`define SDOD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define SDOD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/sdod_pkg.sv =====
// ----------------------------------------------------------------------------
// sdod_pkg: shared types and constants
// Item types, opcode boundaries, codes and controller/datapath interface.
// ----------------------------------------------------------------------------
`default_nettype none

package sdod_pkg;

  // Default sizes and screen geometry
  localparam int SCREEN_CELLS_DEF   = 1000;
  localparam int CODEBOOK_DEPTH_DEF = 176;
  localparam int ROW_WIDTH          = 40;

  localparam int ADDR_W    = 10;
  localparam int CFG_IDX_W = 2;

  // Input item kinds
  localparam logic [1:0] KIND_PAYLOAD = 2'd0;
  localparam logic [1:0] KIND_ENTRY   = 2'd1;
  localparam logic [1:0] KIND_FRAME   = 2'd2;

  // Result status codes
  localparam logic [1:0] OUT_WRITE   = 2'd0;
  localparam logic [1:0] OUT_ILLEGAL = 2'd1;
  localparam logic [1:0] OUT_DROPPED = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_CODEBOOK_SIZE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ABSOLUTE_COUNT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RELATIVE_COUNT = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_FALLBACK_SKIP  = 2'd3;

  // Opcode group boundaries
  localparam logic [7:0] OP_DITTO1   = 8'hB0;
  localparam logic [7:0] OP_DITTO2   = 8'hB8;
  localparam logic [7:0] OP_LITERAL  = 8'hC0;
  localparam logic [7:0] OP_SKIP     = 8'hFF;
  localparam logic [7:0] OP_REP_MASK = 8'h07;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] code_byte;
    logic [7:0] entry_index;
    logic [7:0] entry_skip;
    logic [7:0] entry_value;
  } in_item_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [ADDR_W-1:0] cell_address;
    logic [7:0]        cell_char;
    logic              last;
  } out_item_t;

  // Decoded class of the held item
  typedef enum logic [3:0] {
    CLS_IGNORE,
    CLS_ENTRY,
    CLS_FRAME,
    CLS_CODEBOOK,
    CLS_LITERAL,
    CLS_ILLEGAL,
    CLS_DITTO1,
    CLS_DITTO2,
    CLS_FALLBACK,
    CLS_SKIP
  } cls_t;

  // Source of one cell write
  typedef enum logic [2:0] {
    SEL_CODEBOOK,
    SEL_LITERAL,
    SEL_LAST,
    SEL_SECOND,
    SEL_ILLEGAL
  } sel_t;

  typedef struct packed {
    logic clear;
    logic take;
    logic decode;
    logic emit;
    sel_t sel;
    logic last;
  } cmd_t;

  typedef struct packed {
    cls_t       cls;
    logic [2:0] rep;
    logic       out_free;
    logic       clear_done;
  } sts_t;

endpackage

`default_nettype wire

// ===== src/sdod_ram.sv =====
// ----------------------------------------------------------------------------
// sdod_ram: generic single-port-write RAM
// One write port and one read port with enable and registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module sdod_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ===== src/sdod_ctrl.sv =====
// ----------------------------------------------------------------------------
// sdod_ctrl: decoder controller
// Sequences screen clearing, item accept, decode and the write burst.
// ----------------------------------------------------------------------------
`default_nettype none
`include "screen_delta_opcode_decoder_macros.svh"

module sdod_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  sdod_pkg::sts_t sts,
  output sdod_pkg::cmd_t cmd
);
  import sdod_pkg::*;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_DECODE,
    S_EMIT
  } state_t;

  state_t     state_r;
  logic [3:0] cnt_r;     // writes left after the current one
  logic       pair_r;    // two-write repeat: odd count picks the older write
  sel_t       sel_r;

  // Commands follow the state
  always_comb begin
    cmd.clear  = (state_r == S_CLEAR);
    cmd.take   = (state_r == S_IDLE) && in_valid;
    cmd.decode = (state_r == S_DECODE);
    cmd.emit   = (state_r == S_EMIT);
    cmd.sel    = (pair_r && cnt_r[0]) ? SEL_SECOND : sel_r;
    cmd.last   = (cnt_r == 4'd0);
  end

  assign in_stall = (state_r != S_IDLE);

  // State and burst bookkeeping
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      cnt_r   <= 4'd0;
      pair_r  <= 1'b0;
      sel_r   <= SEL_LAST;
    end else begin
      case (state_r)
        S_CLEAR: begin
          if (sts.clear_done) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            state_r <= S_DECODE;
          end
        end
        S_DECODE: begin
          cnt_r  <= 4'd0;
          pair_r <= 1'b0;
          case (sts.cls)
            CLS_CODEBOOK: begin
              sel_r   <= SEL_CODEBOOK;
              state_r <= S_EMIT;
            end
            CLS_LITERAL: begin
              sel_r   <= SEL_LITERAL;
              state_r <= S_EMIT;
            end
            CLS_ILLEGAL: begin
              sel_r   <= SEL_ILLEGAL;
              state_r <= S_EMIT;
            end
            CLS_DITTO1: begin
              sel_r   <= SEL_LAST;
              cnt_r   <= {1'b0, sts.rep};
              state_r <= S_EMIT;
            end
            CLS_DITTO2: begin
              sel_r   <= SEL_LAST;
              cnt_r   <= {sts.rep, 1'b1};
              pair_r  <= 1'b1;
              state_r <= S_EMIT;
            end
            default: begin
              state_r <= S_IDLE;
            end
          endcase
        end
        S_EMIT: begin
          if (sts.out_free) begin
            if (cnt_r == 4'd0) begin
              state_r <= S_IDLE;
            end else begin
              cnt_r <= cnt_r - 4'd1;
            end
          end
        end
        default: begin
          state_r <= S_CLEAR;
        end
      endcase
    end
  end

  `SDOD_ASSERT_NEXT(a_emit_hold, state_r == S_EMIT && !sts.out_free, state_r == S_EMIT && $stable(cnt_r), "write burst advanced while output register was busy")
  `SDOD_ASSERT_NEXT(a_decode_once, state_r == S_DECODE, state_r == S_EMIT || state_r == S_IDLE, "decode lasted more than one cycle")
  `SDOD_ASSERT_NEXT(a_pair_odd, state_r == S_DECODE && sts.cls == CLS_DITTO2, cnt_r[0] && pair_r, "two-write repeat started without an odd count")

endmodule

`default_nettype wire

// ===== src/sdod_dp.sv =====
// ----------------------------------------------------------------------------
// sdod_dp: decoder datapath
// Config registers, position and history, codebook and screen RAMs, output reg.
// ----------------------------------------------------------------------------
`default_nettype none
`include "screen_delta_opcode_decoder_macros.svh"

module sdod_dp #(
  parameter int SCREEN_CELLS   = sdod_pkg::SCREEN_CELLS_DEF,
  parameter int CODEBOOK_DEPTH = sdod_pkg::CODEBOOK_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  sdod_pkg::cmd_t                 cmd,
  output sdod_pkg::sts_t                 sts,
  input  sdod_pkg::in_item_t             in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output sdod_pkg::out_item_t            out_data,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [sdod_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]                     cfg_data
);
  import sdod_pkg::*;

  localparam int SAW = (SCREEN_CELLS > 1) ? $clog2(SCREEN_CELLS) : 1;
  localparam int CAW = (CODEBOOK_DEPTH > 1) ? $clog2(CODEBOOK_DEPTH) : 1;

  // Configuration
  logic [7:0] cb_size_r, abs_cnt_r, rel_cnt_r, fb_skip_r;

  // Decoder state
  in_item_t   item_r;
  logic [15:0] wp_r;
  logic [7:0] last_skip_r, last_char_r, sec_skip_r, sec_char_r;
  logic       literal_r;
  logic [5:0] pend_skip_r;
  logic       halted_r;
  logic [SAW-1:0] clr_r;

  // Codebook write staging
  logic [7:0] skip_r, val_r;
  logic       add_r;

  // Output register
  logic      out_valid_r;
  out_item_t out_data_r;

  // RAM ports
  logic           cb_we, cb_re;
  logic [CAW-1:0] cb_waddr, cb_raddr;
  logic [15:0]    cb_wdata, cb_rdata;
  logic           scr_we, scr_re;
  logic [SAW-1:0] scr_waddr, scr_raddr;
  logic [7:0]     scr_wdata, scr_rdata;

  logic [7:0]  op;
  logic        in_cb;
  cls_t        cls;
  logic [7:0]  cb_skip, cb_val;
  logic [15:0] cb_pos, rd_pos;
  logic [8:0]  rel_end;
  logic        is_abs, is_rel, above_ok, rd_in, add_nxt;
  logic [7:0]  e_skip, e_char;
  logic [15:0] e_pos;
  logic        e_in, is_write, out_free, fire;
  out_item_t   e_item;

  assign cfg_ready = 1'b1;
  assign op        = item_r.code_byte;

  // Classify the held item
  assign in_cb = (op < cb_size_r) && ({1'b0, op} < 9'(CODEBOOK_DEPTH));

  always_comb begin
    if (item_r.kind == KIND_ENTRY) begin
      cls = CLS_ENTRY;
    end else if (item_r.kind == KIND_FRAME) begin
      cls = CLS_FRAME;
    end else if (item_r.kind != KIND_PAYLOAD || halted_r) begin
      cls = CLS_IGNORE;
    end else if (literal_r) begin
      cls = CLS_LITERAL;
    end else if (in_cb) begin
      cls = CLS_CODEBOOK;
    end else if (op < OP_DITTO1) begin
      cls = CLS_ILLEGAL;
    end else if (op < OP_DITTO2) begin
      cls = CLS_DITTO1;
    end else if (op < OP_LITERAL) begin
      cls = CLS_DITTO2;
    end else if (op < OP_SKIP) begin
      cls = CLS_FALLBACK;
    end else begin
      cls = CLS_SKIP;
    end
  end

  // Codebook RAM: read on accept, write on entry decode
  assign cb_re    = cmd.take;
  assign cb_raddr = ({1'b0, in_data.code_byte} < 9'(CODEBOOK_DEPTH))
                    ? in_data.code_byte[CAW-1:0] : '0;
  assign cb_we    = cmd.decode && (cls == CLS_ENTRY)
                    && ({1'b0, item_r.entry_index} < 9'(CODEBOOK_DEPTH));
  assign cb_waddr = item_r.entry_index[CAW-1:0];
  assign cb_wdata = {item_r.entry_skip, item_r.entry_value};

  sdod_ram #(
    .WIDTH (16),
    .DEPTH (CODEBOOK_DEPTH)
  ) u_cb_ram (
    .clk   (clk),
    .we    (cb_we),
    .waddr (cb_waddr),
    .wdata (cb_wdata),
    .re    (cb_re),
    .raddr (cb_raddr),
    .rdata (cb_rdata)
  );

  // Codebook value class and screen read address
  always_comb begin
    cb_skip  = cb_rdata[15:8];
    cb_val   = cb_rdata[7:0];
    cb_pos   = wp_r + {8'd0, cb_skip};
    rel_end  = {1'b0, abs_cnt_r} + {1'b0, rel_cnt_r};
    is_abs   = (op < abs_cnt_r);
    is_rel   = !is_abs && ({1'b0, op} < rel_end);
    above_ok = (cb_pos >= 16'(ROW_WIDTH));
    rd_pos   = is_rel ? cb_pos : (cb_pos - 16'(ROW_WIDTH));
    rd_in    = (rd_pos < 16'(SCREEN_CELLS));
    add_nxt  = !is_abs && rd_in && (is_rel || above_ok);
  end

  assign scr_re    = cmd.decode && (cls == CLS_CODEBOOK);
  assign scr_raddr = rd_pos[SAW-1:0];

  // Write source selection
  always_comb begin
    case (cmd.sel)
      SEL_CODEBOOK: begin
        e_skip = skip_r;
        e_char = val_r + (add_r ? scr_rdata : 8'd0);
      end
      SEL_LITERAL: begin
        e_skip = {2'b00, pend_skip_r};
        e_char = op;
      end
      SEL_LAST: begin
        e_skip = last_skip_r;
        e_char = last_char_r;
      end
      SEL_SECOND: begin
        e_skip = sec_skip_r;
        e_char = sec_char_r;
      end
      default: begin
        e_skip = 8'd0;
        e_char = op;
      end
    endcase
  end

  assign e_pos    = wp_r + {8'd0, e_skip};
  assign e_in     = (e_pos < 16'(SCREEN_CELLS));
  assign is_write = (cmd.sel != SEL_ILLEGAL);
  assign out_free = !out_valid_r || !out_stall;
  assign fire     = cmd.emit && out_free;

  // Result item
  always_comb begin
    e_item.last = cmd.last;
    if (!is_write) begin
      e_item.status       = OUT_ILLEGAL;
      e_item.cell_address = '0;
      e_item.cell_char    = op;
    end else begin
      e_item.status       = e_in ? OUT_WRITE : OUT_DROPPED;
      e_item.cell_address = e_in ? e_pos[ADDR_W-1:0] : '0;
      e_item.cell_char    = e_char;
    end
  end

  // Screen RAM: clear sweep or cell write
  assign scr_we    = cmd.clear || (fire && is_write && e_in);
  assign scr_waddr = cmd.clear ? clr_r : e_pos[SAW-1:0];
  assign scr_wdata = cmd.clear ? 8'd0 : e_char;

  sdod_ram #(
    .WIDTH (8),
    .DEPTH (SCREEN_CELLS)
  ) u_scr_ram (
    .clk   (clk),
    .we    (scr_we),
    .waddr (scr_waddr),
    .wdata (scr_wdata),
    .re    (scr_re),
    .raddr (scr_raddr),
    .rdata (scr_rdata)
  );

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cb_size_r   <= 8'd0;
      abs_cnt_r   <= 8'd0;
      rel_cnt_r   <= 8'd0;
      fb_skip_r   <= 8'd0;
      wp_r        <= 16'd0;
      last_skip_r <= 8'd0;
      last_char_r <= 8'd0;
      sec_skip_r  <= 8'd0;
      sec_char_r  <= 8'd0;
      literal_r   <= 1'b0;
      pend_skip_r <= 6'd0;
      halted_r    <= 1'b0;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          CFG_CODEBOOK_SIZE:  cb_size_r <= cfg_data;
          CFG_ABSOLUTE_COUNT: abs_cnt_r <= cfg_data;
          CFG_RELATIVE_COUNT: rel_cnt_r <= cfg_data;
          CFG_FALLBACK_SKIP:  fb_skip_r <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.clear) begin
        clr_r <= clr_r + SAW'(1);
      end
      if (cmd.decode) begin
        case (cls)
          CLS_FRAME: begin
            wp_r        <= 16'd0;
            last_skip_r <= 8'd0;
            last_char_r <= 8'd0;
            sec_skip_r  <= 8'd0;
            sec_char_r  <= 8'd0;
            literal_r   <= 1'b0;
            pend_skip_r <= 6'd0;
            halted_r    <= 1'b0;
          end
          CLS_ILLEGAL:  halted_r <= 1'b1;
          CLS_LITERAL:  literal_r <= 1'b0;
          CLS_FALLBACK: begin
            literal_r   <= 1'b1;
            pend_skip_r <= 6'(op - OP_LITERAL);
          end
          CLS_SKIP:     wp_r <= wp_r + {8'd0, fb_skip_r};
          default: ;
        endcase
      end
      if (fire && is_write) begin
        wp_r <= e_pos + 16'd1;
        // Repeats leave the history alone
        if (cmd.sel == SEL_CODEBOOK || cmd.sel == SEL_LITERAL) begin
          sec_skip_r  <= last_skip_r;
          sec_char_r  <= last_char_r;
          last_skip_r <= e_skip;
          last_char_r <= e_char;
        end
      end
      if (fire) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      item_r <= in_data;
    end
    if (cmd.decode) begin
      skip_r <= cb_skip;
      val_r  <= cb_val;
      add_r  <= add_nxt;
    end
    if (fire) begin
      out_data_r <= e_item;
    end
  end

  // Status to controller
  always_comb begin
    sts.cls        = cls;
    sts.rep        = 3'(op & OP_REP_MASK);
    sts.out_free   = out_free;
    sts.clear_done = (clr_r == SAW'(SCREEN_CELLS - 1));
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `SDOD_ASSERT_NOW(a_illegal_nowrite, cmd.emit && cmd.sel == SEL_ILLEGAL, !scr_we, "illegal opcode wrote the screen")
  `SDOD_ASSERT_NEXT(a_pos_quiet, !(cmd.decode || cmd.emit), $stable(wp_r), "position moved outside decode or write")
  `SDOD_ASSERT_NOW(a_halted_quiet, halted_r && cmd.decode, cls != CLS_CODEBOOK && cls != CLS_LITERAL && cls != CLS_ILLEGAL, "halted frame produced a result")

endmodule

`default_nettype wire

// ===== src/screen_delta_opcode_decoder.sv =====
// ----------------------------------------------------------------------------
// screen_delta_opcode_decoder: opcode stream to character screen decoder
// Accept registers the item and codebook read, decode the screen read, and writes
// leave via the output register. in_stall is high while all SCREEN_CELLS (1000)
// cells clear after sync reset and until an item's writes (up to 16) are all out.
// ----------------------------------------------------------------------------
`default_nettype none

module screen_delta_opcode_decoder #(
  parameter int SCREEN_CELLS   = sdod_pkg::SCREEN_CELLS_DEF,
  parameter int CODEBOOK_DEPTH = sdod_pkg::CODEBOOK_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  sdod_pkg::in_item_t             in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output sdod_pkg::out_item_t            out_data,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [sdod_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]                     cfg_data
);
  import sdod_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // Controller
  sdod_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Datapath
  sdod_dp #(
    .SCREEN_CELLS   (SCREEN_CELLS),
    .CODEBOOK_DEPTH (CODEBOOK_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

endmodule

`default_nettype wire

// ===== sim/screen_delta_opcode_decoder_test.sv =====
// ----------------------------------------------------------------------------
// screen_delta_opcode_decoder_test: self-checking bench for the opcode decoder
// Drives directed and random opcode streams across several register settings,
// tracks the screen, codebook and write history in a scoreboard, and checks
// every result item field by field in order, with random idling on both sides.
// ----------------------------------------------------------------------------
module screen_delta_opcode_decoder_test;
  timeunit 1ns;
  timeprecision 1ps;

  import sdod_pkg::*;

  localparam int          SCREEN      = SCREEN_CELLS_DEF;
  localparam int          DEPTH       = CODEBOOK_DEPTH_DEF;
  localparam int          IDLE_LIMIT  = 5000;   // covers the screen clear after reset
  localparam int          SETTLE      = 24;     // longest DITTO burst plus margin
  localparam logic [1:0]  KIND_UNUSED = 2'd3;

  // Scoreboard: tracks decoder state and the queue of expected writes
  class cell_write_board;
    bit [7:0]    book_size, abs_count, rel_count, ff_skip;
    bit [7:0]    cells [SCREEN];
    bit [7:0]    ent_skip [DEPTH];
    bit [7:0]    ent_val [DEPTH];
    bit          ent_loaded [DEPTH];
    bit [15:0]   wpos;
    bit [7:0]    last_skip, last_char, prev_skip, prev_char;
    bit          lit_wait;
    bit [5:0]    lit_skip;
    bit          halted;
    out_item_t   pending_writes[$];
    int          errors;
    int          seen;

    function void set_reg(logic [CFG_IDX_W-1:0] idx, bit [7:0] val);
      case (idx)
        CFG_CODEBOOK_SIZE:  book_size = val;
        CFG_ABSOLUTE_COUNT: abs_count = val;
        CFG_RELATIVE_COUNT: rel_count = val;
        CFG_FALLBACK_SKIP:  ff_skip   = val;
        default: ;
      endcase
    endfunction

    function int book_limit();
      return (book_size > DEPTH) ? DEPTH : int'(book_size);
    endfunction

    function bit [7:0] cell_at(int addr);
      return (addr < SCREEN) ? cells[addr] : 8'h00;
    endfunction

    // Advance by skip, write one cell (or drop it off-screen), advance by one
    function void put_cell(bit [7:0] skip, bit [7:0] ch);
      out_item_t w;
      int        addr;
      wpos = wpos + 16'(skip);
      addr = wpos;
      w.last      = 1'b0;
      w.cell_char = ch;
      if (addr < SCREEN) begin
        cells[addr]    = ch;
        w.status       = OUT_WRITE;
        w.cell_address = addr[ADDR_W-1:0];
      end else begin
        w.status       = OUT_DROPPED;
        w.cell_address = '0;
      end
      pending_writes.push_back(w);
      wpos = wpos + 16'd1;
    endfunction

    function void push_hist(bit [7:0] skip, bit [7:0] ch);
      prev_skip = last_skip;
      prev_char = last_char;
      last_skip = skip;
      last_char = ch;
    endfunction

    // Note one accepted input item and queue the writes it causes
    function void take_item(in_item_t it);
      int        start_count;
      int        op;
      int        reps;
      bit [15:0] p16;
      bit [7:0]  skip, val, ch;
      out_item_t w;
      start_count = pending_writes.size();
      op          = it.code_byte;
      case (it.kind)
        KIND_ENTRY: begin
          if (it.entry_index < DEPTH) begin
            ent_skip[it.entry_index]   = it.entry_skip;
            ent_val[it.entry_index]    = it.entry_value;
            ent_loaded[it.entry_index] = 1'b1;
          end
        end
        KIND_FRAME: begin
          wpos      = '0;
          last_skip = '0;
          last_char = '0;
          prev_skip = '0;
          prev_char = '0;
          lit_wait  = 1'b0;
          lit_skip  = '0;
          halted    = 1'b0;
        end
        KIND_PAYLOAD: begin
          if (halted) begin
            // frame halted: byte dropped silently
          end else if (lit_wait) begin
            lit_wait = 1'b0;
            put_cell({2'b00, lit_skip}, it.code_byte);
            push_hist({2'b00, lit_skip}, it.code_byte);
          end else if (op < book_limit()) begin
            skip = ent_skip[op];
            val  = ent_val[op];
            p16  = wpos + 16'(skip);
            if (op < abs_count)
              ch = val;
            else if (op < int'(abs_count) + int'(rel_count))
              ch = cell_at(p16) + val;
            else if (p16 < ROW_WIDTH)
              ch = val;    // top row: nothing above
            else
              ch = cell_at(int'(p16) - ROW_WIDTH) + val;
            put_cell(skip, ch);
            push_hist(skip, ch);
          end else if (op < OP_DITTO1) begin
            w.status       = OUT_ILLEGAL;
            w.cell_address = '0;
            w.cell_char    = it.code_byte;
            w.last         = 1'b0;
            pending_writes.push_back(w);
            halted = 1'b1;
          end else if (op < OP_DITTO2) begin
            reps = (op & int'(OP_REP_MASK)) + 1;
            repeat (reps) put_cell(last_skip, last_char);
          end else if (op < OP_LITERAL) begin
            reps = (op & int'(OP_REP_MASK)) + 1;
            repeat (reps) begin
              put_cell(prev_skip, prev_char);
              put_cell(last_skip, last_char);
            end
          end else if (op < OP_SKIP) begin
            lit_wait = 1'b1;
            lit_skip = 6'(op - int'(OP_LITERAL));
          end else begin
            wpos = wpos + 16'(ff_skip);
          end
        end
        default: ;
      endcase
      // flag the final write of this item
      if (pending_writes.size() > start_count) begin
        w      = pending_writes.pop_back();
        w.last = 1'b1;
        pending_writes.push_back(w);
      end
    endfunction

    task report(string msg);
      errors++;
      if (errors <= 200)
        $display("%0t: result %0d: %s", $time, seen, msg);
    endtask

    // Compare one accepted result with the oldest expected write
    task check_write(out_item_t got);
      out_item_t want;
      seen++;
      if (pending_writes.size() == 0) begin
        report($sformatf("unexpected result status %0d addr %0d char %02h",
                         got.status, got.cell_address, got.cell_char));
        return;
      end
      want = pending_writes.pop_front();
      if (got.status !== want.status)
        report($sformatf("status %0d, expected %0d", got.status, want.status));
      if (got.cell_address !== want.cell_address)
        report($sformatf("cell_address %0d, expected %0d",
                         got.cell_address, want.cell_address));
      if (got.cell_char !== want.cell_char)
        report($sformatf("cell_char %02h, expected %02h", got.cell_char, want.cell_char));
      if (got.last !== want.last)
        report($sformatf("last %0b, expected %0b", got.last, want.last));
    endtask
  endclass

  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 in_valid  = 1'b0;
  logic                 in_stall;
  in_item_t             in_data   = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  out_item_t            out_data;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [7:0]           cfg_data  = '0;

  cell_write_board board;
  int              idle_pct     = 31;
  int              quiet_cycles = 0;

  screen_delta_opcode_decoder uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // 100 MHz clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Result side: random stall, changed on the falling edge
  always @(negedge clk) begin
    out_stall = rst_n && ($urandom_range(99) < idle_pct);
  end

  // Result check on every accepted item
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      board.check_write(out_data);
  end

  // Watchdog: no handshake on any channel for too long
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= IDLE_LIMIT) begin
      $display("screen_delta_opcode_decoder: mismatch");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Item builders; unused fields carry random bits
  function automatic in_item_t payload_item(bit [7:0] b);
    in_item_t it;
    it.kind        = KIND_PAYLOAD;
    it.code_byte   = b;
    it.entry_index = 8'($urandom);
    it.entry_skip  = 8'($urandom);
    it.entry_value = 8'($urandom);
    return it;
  endfunction

  function automatic in_item_t entry_item(bit [7:0] idx, bit [7:0] skip, bit [7:0] val);
    in_item_t it;
    it             = payload_item(8'($urandom));
    it.kind        = KIND_ENTRY;
    it.entry_index = idx;
    it.entry_skip  = skip;
    it.entry_value = val;
    return it;
  endfunction

  function automatic in_item_t frame_item();
    in_item_t it;
    it      = payload_item(8'($urandom));
    it.kind = KIND_FRAME;
    return it;
  endfunction

  // Mostly short skips so frames stay on screen for a while
  function automatic bit [7:0] rand_skip();
    return ($urandom_range(99) < 90) ? 8'($urandom_range(3)) : 8'($urandom_range(255));
  endfunction

  // Items that the decoder drops without any effect
  function automatic bit no_effect(in_item_t it);
    return (it.kind == KIND_UNUSED) || (it.kind == KIND_PAYLOAD && board.halted) ||
           (it.kind == KIND_ENTRY && it.entry_index >= DEPTH);
  endfunction

  // Opcode choice weighted toward well-formed streams
  function automatic bit [7:0] pick_op(int lim);
    int r;
    r = $urandom_range(99);
    if (board.lit_wait)              return 8'($urandom_range(255));
    if (r < 45 && lim > 0)           return 8'($urandom_range(lim - 1));
    if (r < 55)                      return OP_DITTO1 + 8'($urandom_range(7));
    if (r < 63)                      return OP_DITTO2 + 8'($urandom_range(7));
    if (r < 78)                      return OP_LITERAL + 8'($urandom_range(62));
    if (r < 84)                      return OP_SKIP;
    if (r < 87 && lim < OP_DITTO1)   return 8'($urandom_range(lim, OP_DITTO1 - 1));
    return 8'($urandom_range(255));
  endfunction

  // Present one item from a falling edge and hold it until accepted
  task automatic send_item(input in_item_t it);
    while ($urandom_range(99) < idle_pct) begin
      in_valid = 1'b0;
      in_data  = payload_item(8'($urandom));
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_data  = it;
    do @(posedge clk); while (in_stall);
    board.take_item(it);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    do @(posedge clk); while (!cfg_ready);
    board.set_reg(idx, val);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Wait for every expected write, then let any silent item finish
  task automatic settle();
    in_valid = 1'b0;
    while (board.pending_writes.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic configure(input bit [7:0] size, input bit [7:0] abs_n,
                           input bit [7:0] rel_n, input bit [7:0] ff);
    settle();
    write_reg(CFG_CODEBOOK_SIZE, size);
    write_reg(CFG_ABSOLUTE_COUNT, abs_n);
    write_reg(CFG_RELATIVE_COUNT, rel_n);
    write_reg(CFG_FALLBACK_SKIP, ff);
  endtask

  // Random stream; one pause for a full drain halfway through
  task automatic run_random(input int count);
    int       done;
    int       r;
    int       lim;
    bit       paused;
    bit [7:0] op;
    in_item_t it;
    done   = 0;
    paused = 1'b0;
    send_item(frame_item());
    while (done < count) begin
      r   = $urandom_range(99);
      lim = board.book_limit();
      if (board.halted && r < 70) begin
        it = frame_item();
      end else if (r < 3) begin
        it      = payload_item(8'($urandom));
        it.kind = KIND_UNUSED;
      end else if (r < 7) begin
        it = entry_item(8'($urandom_range(255)), rand_skip(), 8'($urandom));
      end else if (r < 10) begin
        it = frame_item();
      end else begin
        op = pick_op(lim);
        // load a codebook entry before its first use
        if (!board.lit_wait && !board.halted && op < lim && !board.ent_loaded[op]) begin
          send_item(entry_item(op, rand_skip(), 8'($urandom)));
          done++;
        end
        it = payload_item(op);
      end
      if (!no_effect(it)) done++;
      send_item(it);
      if (!paused && done >= count / 2) begin
        paused   = 1'b1;
        in_valid = 1'b0;
        while (board.pending_writes.size() != 0) @(negedge clk);
      end
    end
  endtask

  initial begin
    in_item_t odd;
    board = new();

    // reset, released on a falling edge
    rst_n = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: entries of each class, ignored items, every opcode group
    configure(8'd16, 8'd4, 8'd6, 8'd3);
    send_item(entry_item(8'd0, 8'd0, 8'h41));         // absolute
    send_item(entry_item(8'd4, 8'd1, 8'hFF));         // relative
    send_item(entry_item(8'd10, 8'd2, 8'h01));        // above
    send_item(entry_item(8'd15, 8'hFF, 8'h80));       // largest skip
    send_item(entry_item(8'd200, 8'hFF, 8'hFF));      // index past codebook
    odd      = payload_item(8'hFF);
    odd.kind = KIND_UNUSED;                           // unknown kind
    send_item(odd);
    send_item(frame_item());
    send_item(payload_item(8'd0));
    send_item(payload_item(8'd10));                   // above read in top row
    send_item(payload_item(8'd4));
    send_item(payload_item(OP_LITERAL + 8'd5));
    send_item(payload_item(8'hFF));                   // literal byte
    send_item(payload_item(OP_DITTO1 | OP_REP_MASK));
    send_item(payload_item(OP_DITTO2 | OP_REP_MASK)); // longest burst
    send_item(payload_item(OP_SKIP));
    send_item(payload_item(8'd10));                   // above read below top row
    send_item(payload_item(8'd15));
    send_item(payload_item(OP_LITERAL));
    send_item(payload_item(8'h00));
    send_item(payload_item(OP_SKIP - 8'd1));
    send_item(payload_item(8'h5A));
    send_item(payload_item(8'h20));                   // illegal, halts the frame
    send_item(payload_item(8'd0));                    // dropped while halted

    // Directed: writes and reads past the end of the screen
    configure(8'd16, 8'd4, 8'd6, 8'hFF);
    send_item(frame_item());
    repeat (4) send_item(payload_item(OP_SKIP));
    send_item(payload_item(8'd4));                    // relative read off screen
    send_item(payload_item(OP_SKIP));
    send_item(payload_item(8'd10));                   // above read off screen
    send_item(payload_item(OP_DITTO1));

    // Random phases across register settings
    configure(8'd176, 8'd176, 8'd0, 8'd0);
    run_random(16);
    configure(8'd176, 8'd0, 8'd0, 8'hFF);
    run_random(16);
    configure(8'd0, 8'd0, 8'd176, 8'd1);
    run_random(10);
    idle_pct = 0;                                     // no idling on either side
    configure(8'd176, 8'd60, 8'd176, 8'd40);
    run_random(20);
    idle_pct = 31;
    configure(8'd40, 8'd10, 8'd20, 8'd7);
    run_random(16);

    settle();
    if (board.errors == 0)
      $display("screen_delta_opcode_decoder: match");
    else
      $display("screen_delta_opcode_decoder: mismatch");
    $finish;
  end

endmodule
